// ----- hdl/pwd_pkg.sv -----
// Shared types, codes and helpers for the per-channel trip watchdog.
package pwd_pkg;

	localparam int MODE_W   = 3;
	localparam int CH_W     = 8;
	localparam int SAMPLE_W = 32;
	localparam int CNT_W    = 16;
	localparam int LIM_W    = 31;
	localparam int WIN_W    = 33;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CH_SPACE = 1 << CH_W;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_LOAD  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BEAM  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SETPT = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CURR  = 3'd4;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BEAM_LIMIT  = 3'd0,
		CFG_BEAM_TRIP   = 3'd1,
		CFG_SETPT_TRIP  = 3'd2,
		CFG_CURR_TRIP   = 3'd3,
		CFG_CURR_MARGIN = 3'd4,
		CFG_CURR_SCALE  = 3'd5,
		CFG_DIS_FIRST   = 3'd6,
		CFG_DIS_SECOND  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [LIM_W-1:0] beam_limit;
		logic [CNT_W-1:0] beam_trip;
		logic [CNT_W-1:0] setpt_trip;
		logic [CNT_W-1:0] curr_trip;
		logic [LIM_W-1:0] curr_margin;
		logic [CNT_W-1:0] curr_scale;
		logic [CH_W-1:0]  dis_first;
		logic [CH_W-1:0]  dis_second;
	} cfg_t;

	// Per-channel record kept in the channel memory
	typedef struct packed {
		logic [LIM_W-1:0] limit;
		logic [WIN_W-1:0] win_hi;
		logic [WIN_W-1:0] win_lo;
		logic [CNT_W-1:0] beam_cnt;
		logic [CNT_W-1:0] curr_cnt;
		logic [CNT_W-1:0] setpt_cnt;
	} rec_t;

	// Precomputed item, handed from the front stage to the update stage
	typedef struct packed {
		logic [MODE_W-1:0]       mode;
		logic [CH_W-1:0]         channel;
		logic                    ch_ok;
		logic                    last;
		logic                    beam_err;
		logic [LIM_W-1:0]        load_lim;
		logic signed [WIN_W-1:0] neg;
		logic signed [WIN_W-1:0] scaled;
	} prep_t;

	typedef struct packed {
		logic             tripped;
		logic [CNT_W-1:0] channel_count;
		logic [CNT_W-1:0] beam_total;
		logic [CNT_W-1:0] current_total;
		logic [CNT_W-1:0] setpoint_total;
	} res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

endpackage

// ----- hdl/pwd_ifs.sv -----
// Channel interfaces: item input, result output and configuration write.
interface pwd_in_if import pwd_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [MODE_W-1:0]          mode;
	logic [CH_W-1:0]            channel;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, mode, channel, sample, input ready);
	modport sink   (input valid, mode, channel, sample, output ready);
endinterface

interface pwd_out_if import pwd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             tripped;
	logic [CNT_W-1:0] channel_count;
	logic [CNT_W-1:0] beam_total;
	logic [CNT_W-1:0] current_total;
	logic [CNT_W-1:0] setpoint_total;

	modport source (output valid, tripped, channel_count, beam_total, current_total,
		setpoint_total, input ready);
	modport sink   (input valid, tripped, channel_count, beam_total, current_total,
		setpoint_total, output ready);
endinterface

interface pwd_cfg_if import pwd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/pwd_prep.sv -----
// Front stage: input register, magnitude, current scaling and beam test.
module pwd_prep import pwd_pkg::*; #(
	parameter int CHANNELS = 256
) (
	input  logic                       clk,
	input  logic                       accept,
	input  logic                       adv,
	input  logic [MODE_W-1:0]          in_mode,
	input  logic [CH_W-1:0]            in_channel,
	input  logic signed [SAMPLE_W-1:0] in_sample,
	input  cfg_t                       cfg,
	output logic [CH_W-1:0]            ch_s1,
	output prep_t                      prep_s2
);

	localparam int CMP_W = $clog2(CHANNELS + 1) + 1;
	localparam logic [CMP_W-1:0] CH_LIMIT = CMP_W'(CHANNELS);
	localparam logic [CMP_W-1:0] CH_LAST  = CMP_W'(CHANNELS - 1);

	logic [MODE_W-1:0]          mode_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;

	logic [SAMPLE_W-1:0]           mag;
	logic [SAMPLE_W+CNT_W-1:0]     prod;
	logic signed [WIN_W-1:0]       q;
	logic [CMP_W-1:0]              ch_w;
	prep_t                         prep;

	// Input register
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1   <= in_mode;
			ch_s1     <= in_channel;
			sample_s1 <= in_sample;
		end
	end

	// Magnitude, scaled current truncated toward zero, beam and window operands
	always_comb begin
		mag  = sample_s1[SAMPLE_W-1] ? SAMPLE_W'(-sample_s1) : SAMPLE_W'(sample_s1);
		prod = (SAMPLE_W+CNT_W)'(mag) * (SAMPLE_W+CNT_W)'(cfg.curr_scale);
		q    = $signed({1'b0, prod[SAMPLE_W+CNT_W-1:CNT_W]});
		ch_w = CMP_W'(ch_s1);

		prep.mode     = mode_s1;
		prep.channel  = ch_s1;
		prep.ch_ok    = ch_w < CH_LIMIT;
		prep.last     = ch_w == CH_LAST;
		prep.beam_err = (mag >= {1'b0, cfg.beam_limit}) &&
			(ch_s1 != cfg.dis_first) && (ch_s1 != cfg.dis_second);
		prep.load_lim = sample_s1[SAMPLE_W-1] ? '0 : sample_s1[LIM_W-1:0];
		prep.neg      = -$signed({sample_s1[SAMPLE_W-1], sample_s1});
		prep.scaled   = sample_s1[SAMPLE_W-1] ? -q : q;
	end

	// Stage register into the update stage
	always_ff @(posedge clk) begin
		if (adv) begin
			prep_s2 <= prep;
		end
	end

endmodule

// ----- hdl/pwd_chan_mem.sv -----
// Per-channel record memory with valid bits and write-to-read forwarding.
module pwd_chan_mem import pwd_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_idx,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_idx,
	input  rec_t                     wr_rec,
	output rec_t                     rd_rec
);

	rec_t             mem [DEPTH];
	rec_t             mem_q;
	rec_t             fwd_rec_q;
	logic [DEPTH-1:0] vld_q;
	logic             rvld_q;
	logic             fwd_q;

	// Storage write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_rec;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_q <= mem[rd_idx];
		end
	end

	// Last written record, for a read that coincides with its write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_rec_q <= wr_rec;
		end
	end

	// Valid bits and forward flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
			fwd_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_idx];
				fwd_q  <= wr_en && (wr_idx == rd_idx);
			end
		end
	end

	// Unwritten entries read as zero
	always_comb begin
		if (fwd_q) begin
			rd_rec = fwd_rec_q;
		end else if (rvld_q) begin
			rd_rec = mem_q;
		end else begin
			rd_rec = '0;
		end
	end

endmodule

// ----- hdl/pwd_eval.sv -----
// Update stage: counter and window update, trip totals, result register.
module pwd_eval import pwd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  prep_t prep,
	input  rec_t  rec,
	input  cfg_t  cfg,
	output logic  wr_en,
	output rec_t  wr_rec,
	output res_t  res_q
);

	logic [CNT_W-1:0] beam_sum_q, curr_sum_q, setpt_sum_q;
	logic [CNT_W-1:0] beam_sum_n, curr_sum_n, setpt_sum_n;
	logic [CNT_W-1:0] cnt, cc;
	logic             we;
	logic signed [WIN_W-1:0] hi, lo, m, lim;
	rec_t             nr;

	always_comb begin
		nr          = rec;
		we          = 1'b0;
		cc          = '0;
		cnt         = '0;
		beam_sum_n  = beam_sum_q;
		curr_sum_n  = curr_sum_q;
		setpt_sum_n = setpt_sum_q;
		lim = $signed({2'b00, rec.limit});
		m   = $signed({2'b00, cfg.curr_margin});
		hi  = lim - prep.scaled;
		lo  = -lim - prep.scaled;

		unique case (prep.mode)
			MODE_LOAD: begin
				if (prep.ch_ok) begin
					we           = 1'b1;
					nr.limit     = prep.load_lim;
					nr.win_hi    = {2'b00, prep.load_lim};
					nr.win_lo    = -{2'b00, prep.load_lim};
					nr.beam_cnt  = '0;
					nr.curr_cnt  = '0;
					nr.setpt_cnt = '0;
				end
			end
			MODE_CLEAR: begin
				beam_sum_n  = '0;
				curr_sum_n  = '0;
				setpt_sum_n = '0;
			end
			MODE_BEAM: begin
				if (prep.ch_ok) begin
					we = 1'b1;
					if (prep.beam_err) begin
						cnt = sat_inc(rec.beam_cnt);
						if (cnt >= cfg.beam_trip) begin
							beam_sum_n = sat_inc(beam_sum_q);
						end
					end
					nr.beam_cnt = cnt;
					cc          = cnt;
				end
			end
			MODE_SETPT: begin
				if (prep.ch_ok) begin
					// the last channel only reports its counter
					if (!prep.last) begin
						we = 1'b1;
						if ((prep.neg >= $signed(rec.win_hi)) ||
							(prep.neg <= $signed(rec.win_lo))) begin
							cnt = sat_inc(rec.setpt_cnt);
							if (cnt >= cfg.setpt_trip) begin
								setpt_sum_n = sat_inc(setpt_sum_q);
							end
						end
						nr.setpt_cnt = cnt;
					end
					cc = nr.setpt_cnt;
				end
			end
			MODE_CURR: begin
				if (prep.ch_ok) begin
					if (!prep.last) begin
						we        = 1'b1;
						nr.win_hi = hi;
						nr.win_lo = lo;
						if ((hi <= lo) || (hi < m) || (lo > -m) ||
							(hi <= 33'sd0) || (lo >= 33'sd0)) begin
							nr.curr_cnt = sat_inc(rec.curr_cnt);
							if (nr.curr_cnt >= cfg.curr_trip) begin
								curr_sum_n = sat_inc(curr_sum_q);
							end
						end
					end
					cc = nr.curr_cnt;
				end
			end
			default: begin
			end
		endcase
	end

	assign wr_en  = adv && we;
	assign wr_rec = nr;

	// Trip totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_sum_q  <= '0;
			curr_sum_q  <= '0;
			setpt_sum_q <= '0;
		end else if (adv) begin
			beam_sum_q  <= beam_sum_n;
			curr_sum_q  <= curr_sum_n;
			setpt_sum_q <= setpt_sum_n;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.tripped        <= (beam_sum_n != '0) || (curr_sum_n != '0) ||
				(setpt_sum_n != '0);
			res_q.channel_count  <= cc;
			res_q.beam_total     <= beam_sum_n;
			res_q.current_total  <= curr_sum_n;
			res_q.setpoint_total <= setpt_sum_n;
		end
	end

endmodule

// ----- hdl/per_channel_trip_watchdog.sv -----
// Results pass through the input, read and result registers, each held by result back-pressure.
// Throughput: one item per cycle while the result port is not stalled; the channel
// record memory is read one stage after the input register and written back from the update
// stage, with a forwarding register covering back-to-back items on the same channel.
// Reset: arst_n clears the pipeline, totals, registers to defaults and the
// per-entry valid bits at once; there is no clearing pass.
module per_channel_trip_watchdog import pwd_pkg::*; #(
	parameter int CHANNELS = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	pwd_in_if.sink   items,
	pwd_out_if.source results,
	pwd_cfg_if.sink  cfg
);

	localparam int DEPTH = (CHANNELS < CH_SPACE) ? CHANNELS : CH_SPACE;
	localparam int IW    = $clog2(DEPTH);

	logic  v1_q, v2_q, vo_q;
	logic  accept, adv2, adv_o;
	logic  wr_en;
	logic [CH_W-1:0] ch_s1;
	prep_t prep_s2;
	rec_t  rd_rec, wr_rec;
	res_t  res_q;
	cfg_t  cfg_q;

	// Pipeline handshake
	assign adv_o       = v2_q && (!vo_q || results.ready);
	assign adv2        = v1_q && (!v2_q || adv_o);
	assign items.ready = !v1_q || adv2;
	assign accept      = items.valid && items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (accept) begin
				v1_q <= 1'b1;
			end else if (adv2) begin
				v1_q <= 1'b0;
			end
			if (adv2) begin
				v2_q <= 1'b1;
			end else if (adv_o) begin
				v2_q <= 1'b0;
			end
			if (adv_o) begin
				vo_q <= 1'b1;
			end else if (results.ready) begin
				vo_q <= 1'b0;
			end
		end
	end

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beam_limit  <= 31'd100000;
			cfg_q.beam_trip   <= 16'd3;
			cfg_q.setpt_trip  <= 16'd3;
			cfg_q.curr_trip   <= 16'd1;
			cfg_q.curr_margin <= '0;
			cfg_q.curr_scale  <= 16'd1;
			cfg_q.dis_first   <= 8'd75;
			cfg_q.dis_second  <= 8'd78;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_BEAM_LIMIT:  cfg_q.beam_limit  <= cfg.data[LIM_W-1:0];
				CFG_BEAM_TRIP:   cfg_q.beam_trip   <= cfg.data[CNT_W-1:0];
				CFG_SETPT_TRIP:  cfg_q.setpt_trip  <= cfg.data[CNT_W-1:0];
				CFG_CURR_TRIP:   cfg_q.curr_trip   <= cfg.data[CNT_W-1:0];
				CFG_CURR_MARGIN: cfg_q.curr_margin <= cfg.data[LIM_W-1:0];
				CFG_CURR_SCALE:  cfg_q.curr_scale  <= cfg.data[CNT_W-1:0];
				CFG_DIS_FIRST:   cfg_q.dis_first   <= cfg.data[CH_W-1:0];
				CFG_DIS_SECOND:  cfg_q.dis_second  <= cfg.data[CH_W-1:0];
			endcase
		end
	end

	pwd_prep #(
		.CHANNELS(CHANNELS)
	) u_prep (
		.clk        (clk),
		.accept     (accept),
		.adv        (adv2),
		.in_mode    (items.mode),
		.in_channel (items.channel),
		.in_sample  (items.sample),
		.cfg        (cfg_q),
		.ch_s1      (ch_s1),
		.prep_s2    (prep_s2)
	);

	pwd_chan_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (adv2),
		.rd_idx (ch_s1[IW-1:0]),
		.wr_en  (wr_en),
		.wr_idx (prep_s2.channel[IW-1:0]),
		.wr_rec (wr_rec),
		.rd_rec (rd_rec)
	);

	pwd_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv_o),
		.prep   (prep_s2),
		.rec    (rd_rec),
		.cfg    (cfg_q),
		.wr_en  (wr_en),
		.wr_rec (wr_rec),
		.res_q  (res_q)
	);

	// Result port
	assign results.valid          = vo_q;
	assign results.tripped        = res_q.tripped;
	assign results.channel_count  = res_q.channel_count;
	assign results.beam_total     = res_q.beam_total;
	assign results.current_total  = res_q.current_total;
	assign results.setpoint_total = res_q.setpoint_total;

endmodule

// ----- hdl/pwd_check.sv -----
// Port-level checks for the trip watchdog and their bind.
module pwd_check import pwd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic             tripped,
	input logic [CNT_W-1:0] channel_count,
	input logic [CNT_W-1:0] beam_total,
	input logic [CNT_W-1:0] current_total,
	input logic [CNT_W-1:0] setpoint_total
);

	// Trip flag mirrors the totals it reports with
	a_trip_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tripped == ((beam_total != '0) || (current_total != '0) ||
			(setpoint_total != '0))))
		else $error("tripped disagrees with totals");

	// Input backpressure only when the result side is stalled
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while result side is free");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(tripped) &&
			$stable(channel_count) && $stable(beam_total) &&
			$stable(current_total) && $stable(setpoint_total)))
		else $error("stalled result changed");

endmodule

bind per_channel_trip_watchdog pwd_check u_pwd_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (items.ready),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.tripped        (results.tripped),
	.channel_count  (results.channel_count),
	.beam_total     (results.beam_total),
	.current_total  (results.current_total),
	.setpoint_total (results.setpoint_total)
);
